// ===== rtl/eilc_pkg.sv =====
// Package for the external interrupt line controller.
// Holds field widths, function and register codes, and the register set struct.
// No dependencies.
package eilc_pkg;

    localparam int EILC_NUM_LINES = 16;
    localparam int EILC_MAX_LINES = 16;
    localparam int EILC_NUM_PORTS = 8;
    localparam int EILC_PORT_W    = 16;
    localparam int EILC_SEL_W     = 4;
    localparam int EILC_SEL_REGS  = 4;
    localparam int EILC_REG_W     = 16;
    localparam int EILC_FUNC_W    = 2;
    localparam int EILC_PINS_W    = 64;
    localparam int EILC_ADDR_W    = 5;
    localparam int EILC_DATA_W    = 32;
    localparam int EILC_S_TDATA_W = 144;
    localparam int EILC_M_TDATA_W = 24;

    typedef enum logic [EILC_FUNC_W-1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_CLEAR  = 2'd1,
        FUNC_READ   = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        REG_MASK      = 3'd0,
        REG_RISE_EN   = 3'd1,
        REG_FALL_EN   = 3'd2,
        REG_SEL_0_3   = 3'd3,
        REG_SEL_4_7   = 3'd4,
        REG_SEL_8_11  = 3'd5,
        REG_SEL_12_15 = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [EILC_REG_W-1:0]                    mask;
        logic [EILC_REG_W-1:0]                    rise_en;
        logic [EILC_REG_W-1:0]                    fall_en;
        logic [EILC_SEL_REGS-1:0][EILC_REG_W-1:0] sel;
    } cfg_t;

endpackage

// ===== rtl/eilc_regs.sv =====
// APB register file: mask, edge enables and port selects.
// Depends on eilc_pkg.
module eilc_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [eilc_pkg::EILC_ADDR_W-1:0] paddr,
    input  logic [eilc_pkg::EILC_DATA_W-1:0] pwdata,
    output logic [eilc_pkg::EILC_DATA_W-1:0] prdata,
    output logic                           pready,
    output eilc_pkg::cfg_t                 cfg
);
    import eilc_pkg::*;

    cfg_t                  cfg_reg;
    cfg_t                  cfg_next;
    logic [2:0]            idx;
    logic                  wr_en;
    logic [EILC_REG_W-1:0] wdata;
    logic [EILC_REG_W-1:0] rdata;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign wdata  = pwdata[EILC_REG_W-1:0];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;
    assign prdata = EILC_DATA_W'(rdata);

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_MASK:      cfg_next.mask    = wdata;
                REG_RISE_EN:   cfg_next.rise_en = wdata;
                REG_FALL_EN:   cfg_next.fall_en = wdata;
                REG_SEL_0_3:   cfg_next.sel[0]  = wdata;
                REG_SEL_4_7:   cfg_next.sel[1]  = wdata;
                REG_SEL_8_11:  cfg_next.sel[2]  = wdata;
                REG_SEL_12_15: cfg_next.sel[3]  = wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_MASK:      rdata = cfg_reg.mask;
            REG_RISE_EN:   rdata = cfg_reg.rise_en;
            REG_FALL_EN:   rdata = cfg_reg.fall_en;
            REG_SEL_0_3:   rdata = cfg_reg.sel[0];
            REG_SEL_4_7:   rdata = cfg_reg.sel[1];
            REG_SEL_8_11:  rdata = cfg_reg.sel[2];
            REG_SEL_12_15: rdata = cfg_reg.sel[3];
            default:       rdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/eilc_edge.sv =====
// Line routing, edge detection and pending state.
// Depends on eilc_pkg.
module eilc_edge #(
    parameter int NUM_LINES = eilc_pkg::EILC_NUM_LINES
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             step,
    input  logic [eilc_pkg::EILC_FUNC_W-1:0] func,
    input  logic [eilc_pkg::EILC_PINS_W-1:0] pins_lo,
    input  logic [eilc_pkg::EILC_PINS_W-1:0] pins_hi,
    input  logic [eilc_pkg::EILC_REG_W-1:0]  clear_bits,
    input  eilc_pkg::cfg_t                   cfg,
    output logic [NUM_LINES-1:0]             pending_next
);
    import eilc_pkg::*;

    logic [7:0][EILC_PORT_W-1:0] all_pins;
    logic [NUM_LINES-1:0]        cur;
    logic [NUM_LINES-1:0]        prev_reg;
    logic [NUM_LINES-1:0]        prev_next;
    logic [NUM_LINES-1:0]        pending_reg;
    logic                        valid_reg;
    logic                        valid_next;
    logic [NUM_LINES-1:0]        hit;

    assign all_pins = {pins_hi, pins_lo};

    for (genvar i = 0; i < NUM_LINES; i++) begin : g_line
        logic [EILC_SEL_W-1:0] sel;
        assign sel = cfg.sel[i/4][(i%4)*EILC_SEL_W +: EILC_SEL_W];
        assign cur[i] = (32'(sel) < EILC_NUM_PORTS) ? all_pins[sel[2:0]][i] : 1'b0;
    end

    assign hit = ((cur & ~prev_reg & cfg.rise_en[NUM_LINES-1:0])
               | (~cur & prev_reg & cfg.fall_en[NUM_LINES-1:0]))
               & cfg.mask[NUM_LINES-1:0];

    always_comb begin
        pending_next = pending_reg;
        prev_next    = prev_reg;
        valid_next   = valid_reg;
        case (func)
            FUNC_SAMPLE: begin
                if (valid_reg) begin
                    pending_next = pending_reg | hit;
                end
                prev_next  = cur;
                valid_next = 1'b1;
            end
            FUNC_CLEAR: begin
                pending_next = pending_reg & ~clear_bits[NUM_LINES-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            prev_reg    <= '0;
            valid_reg   <= 1'b0;
        end else if (step) begin
            pending_reg <= pending_next;
            prev_reg    <= prev_next;
            valid_reg   <= valid_next;
        end
    end

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(pending_reg) && $stable(prev_reg) && $stable(valid_reg))
        else $error("state moved without a beat");

    a_read_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        step && func == FUNC_READ |=> $stable(pending_reg) && $stable(prev_reg))
        else $error("read beat changed state");

    a_clear_no_set: assert property (@(posedge aclk) disable iff (!aresetn)
        step && func == FUNC_CLEAR |=> (pending_reg & ~$past(pending_reg)) == '0)
        else $error("clear beat set a pending bit");

    a_first_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        step && func == FUNC_SAMPLE && !valid_reg |=> $stable(pending_reg) && valid_reg)
        else $error("first sample raised a pending bit");

endmodule

// ===== rtl/external_interrupt_line_controller.sv =====
// External interrupt line controller, top level.
// A beat passes the input register, then the result register, before its result beat.
// Throughput: one beat per cycle, but a stalled result blocks a full input register.
// Reset: synchronous active-low aresetn clears registers, pending bits and stored levels.
// Depends on eilc_pkg, eilc_regs, eilc_edge.
module external_interrupt_line_controller #(
    parameter int NUM_LINES = eilc_pkg::EILC_NUM_LINES
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [eilc_pkg::EILC_ADDR_W-1:0]     paddr,
    input  logic [eilc_pkg::EILC_DATA_W-1:0]     pwdata,
    output logic [eilc_pkg::EILC_DATA_W-1:0]     prdata,
    output logic                                 pready,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // pins_ports_0_3 [63:0], pins_ports_4_7 [127:64], clear_bits [143:128]
    input  logic [eilc_pkg::EILC_S_TDATA_W-1:0]  s_tdata,
    // func [1:0]
    input  logic [eilc_pkg::EILC_FUNC_W-1:0]     s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // pending_lines [15:0], irq_any [16], zero [23:17]
    output logic [eilc_pkg::EILC_M_TDATA_W-1:0]  m_tdata
);
    import eilc_pkg::*;

    cfg_t                    cfg;
    logic                    in_valid_reg;
    logic                    in_valid_next;
    logic [EILC_S_TDATA_W-1:0] in_data_reg;
    logic [EILC_FUNC_W-1:0]  in_func_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [EILC_REG_W-1:0]   out_pend_reg;
    logic                    out_irq_reg;
    logic                    advance;
    logic                    s_beat;
    logic [NUM_LINES-1:0]    pending_next;

    eilc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    eilc_edge #(
        .NUM_LINES (NUM_LINES)
    ) u_edge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .func         (in_func_reg),
        .pins_lo      (in_data_reg[63:0]),
        .pins_hi      (in_data_reg[127:64]),
        .clear_bits   (in_data_reg[143:128]),
        .cfg          (cfg),
        .pending_next (pending_next)
    );

    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign s_beat         = s_tvalid && s_tready;
    assign in_valid_next  = s_beat || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = EILC_M_TDATA_W'({out_irq_reg, out_pend_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            in_data_reg <= s_tdata;
            in_func_reg <= s_tuser;
        end
        if (advance) begin
            out_pend_reg <= EILC_REG_W'(pending_next);
            out_irq_reg  <= |pending_next;
        end
    end

endmodule

// ===== dv/external_interrupt_line_controller_tb.sv =====
// Testbench for external_interrupt_line_controller: drives sample, clear and read beats,
// writes the APB registers between phases and checks every result beat against its own model.
// Depends on eilc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module external_interrupt_line_controller_tb;
    import eilc_pkg::*;

    localparam logic [EILC_FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int CHUNK_BEATS  = 100;
    localparam int NUM_CHUNKS   = 7;

    // Model of the pending logic and store of expected result beats
    class pending_scoreboard;
        logic [EILC_REG_W-1:0] mask_r;
        logic [EILC_REG_W-1:0] rise_r;
        logic [EILC_REG_W-1:0] fall_r;
        logic [EILC_REG_W-1:0] sel_r [EILC_SEL_REGS];
        logic [15:0]           last_levels;
        bit                    levels_seen;
        logic [15:0]           pending_now;
        logic [16:0]           pending_q [$];
        int                    mismatches;
        int                    checked;
        int                    accepted;

        function new();
            mask_r      = '0;
            rise_r      = '0;
            fall_r      = '0;
            foreach (sel_r[i]) sel_r[i] = '0;
            last_levels = '0;
            levels_seen = 1'b0;
            pending_now = '0;
            mismatches  = 0;
            checked     = 0;
            accepted    = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [EILC_REG_W-1:0] v);
            case (idx)
                REG_MASK:      mask_r   = v;
                REG_RISE_EN:   rise_r   = v;
                REG_FALL_EN:   fall_r   = v;
                REG_SEL_0_3:   sel_r[0] = v;
                REG_SEL_4_7:   sel_r[1] = v;
                REG_SEL_8_11:  sel_r[2] = v;
                REG_SEL_12_15: sel_r[3] = v;
                default: ;
            endcase
        endfunction

        function logic [15:0] line_levels(logic [63:0] lo, logic [63:0] hi);
            logic [15:0]  lv;
            logic [3:0]   port;
            logic [127:0] all_pins;
            lv       = '0;
            all_pins = {hi, lo};
            for (int i = 0; i < EILC_NUM_LINES; i++) begin
                port = sel_r[i / 4][(i % 4) * EILC_SEL_W +: EILC_SEL_W];
                if (port < EILC_NUM_PORTS)
                    lv[i] = all_pins[port * EILC_PORT_W + i];
            end
            return lv;
        endfunction

        function void note_beat(logic [1:0] fn, logic [63:0] lo, logic [63:0] hi,
                                logic [15:0] clr);
            logic [15:0] cur;
            logic [15:0] rise;
            logic [15:0] fall;
            logic [15:0] lm;
            lm = 16'((17'd1 << EILC_NUM_LINES) - 17'd1);
            case (fn)
                FUNC_SAMPLE: begin
                    cur = line_levels(lo, hi) & lm;
                    if (levels_seen) begin
                        rise        = cur & ~last_levels & rise_r;
                        fall        = ~cur & last_levels & fall_r;
                        pending_now = pending_now | ((rise | fall) & mask_r & lm);
                    end
                    last_levels = cur;
                    levels_seen = 1'b1;
                end
                FUNC_CLEAR: pending_now = pending_now & ~clr;
                default: ;
            endcase
            pending_now = pending_now & lm;
            pending_q.push_back({pending_now != 16'd0, pending_now});
            accepted++;
        endfunction

        task report(string what, int got, int want);
            $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
            mismatches++;
        endtask

        task check_result(logic [EILC_M_TDATA_W-1:0] beat);
            logic [16:0] want;
            if (pending_q.size() == 0) begin
                report("result beat with nothing outstanding", int'(beat), 0);
            end else begin
                want = pending_q.pop_front();
                checked++;
                if (beat[15:0] !== want[15:0])
                    report("pending_lines", int'(beat[15:0]), int'(want[15:0]));
                if (beat[16] !== want[16])
                    report("irq_any", int'(beat[16]), int'(want[16]));
                if (beat[23:17] !== 7'd0)
                    report("padding", int'(beat[23:17]), 0);
            end
        endtask

        task check_leftover();
            if (pending_q.size() != 0)
                report("results never delivered", pending_q.size(), 0);
        endtask
    endclass

    logic                         aclk;
    logic                         aresetn;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [EILC_ADDR_W-1:0]       paddr;
    logic [EILC_DATA_W-1:0]       pwdata;
    logic [EILC_DATA_W-1:0]       prdata;
    logic                         pready;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [EILC_S_TDATA_W-1:0]    s_tdata;
    logic [EILC_FUNC_W-1:0]       s_tuser;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [EILC_M_TDATA_W-1:0]    m_tdata;

    pending_scoreboard sb = new();

    int          tx_idle_pct;
    int          rx_idle_pct;
    int          hold_requests;
    int          hold_served;
    int          hold_left;
    int          settings_used;
    logic [63:0] pins_lo;
    logic [63:0] pins_hi;

    external_interrupt_line_controller DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: check accepted beats, then choose tready for the next cycle
    initial begin
        hold_served = 0;
        hold_left   = 0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task write_reg(reg_idx_t idx, logic [EILC_REG_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(EILC_DATA_W - EILC_REG_W){1'b0}}, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task apply_settings(logic [15:0] m, logic [15:0] r, logic [15:0] f, logic [15:0] s0,
                        logic [15:0] s1, logic [15:0] s2, logic [15:0] s3);
        write_reg(REG_MASK, m);
        write_reg(REG_RISE_EN, r);
        write_reg(REG_FALL_EN, f);
        write_reg(REG_SEL_0_3, s0);
        write_reg(REG_SEL_4_7, s1);
        write_reg(REG_SEL_8_11, s2);
        write_reg(REG_SEL_12_15, s3);
        settings_used++;
    endtask

    task send_beat(logic [1:0] fn, logic [63:0] lo, logic [63:0] hi, logic [15:0] clr);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {clr, hi, lo};
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(fn, lo, hi, clr);
    endtask

    task wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task send_random_beat();
        logic [1:0]  fn;
        logic [15:0] clr;
        int          pick;
        pick = $urandom_range(99);
        clr  = 16'($urandom);
        if (pick < 58)      fn = FUNC_SAMPLE;
        else if (pick < 78) fn = FUNC_CLEAR;
        else if (pick < 94) fn = FUNC_READ;
        else                fn = FUNC_UNUSED;
        pick = $urandom_range(99);
        if (pick < 40) begin
            pins_lo = {$urandom, $urandom};
            pins_hi = {$urandom, $urandom};
        end else if (pick < 45) begin
            pins_lo = '0;
            pins_hi = '0;
        end else if (pick < 50) begin
            pins_lo = '1;
            pins_hi = '1;
        end else begin
            repeat ($urandom_range(1, 6)) begin
                pins_lo[$urandom_range(63)] ^= 1'b1;
                pins_hi[$urandom_range(63)] ^= 1'b1;
            end
        end
        send_beat(fn, pins_lo, pins_hi, clr);
    endtask

    initial begin
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= FUNC_READ;
        m_tready      <= 1'b0;
        aresetn       <= 1'b0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        hold_requests = 0;
        settings_used = 0;
        pins_lo       = '0;
        pins_hi       = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: first sample, both edge directions, unused code, out-of-range ports
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h3210, 16'h7654, 16'h9A10, 16'hFFFF);
        send_beat(FUNC_READ,   '0, '0, 16'h0000);
        send_beat(FUNC_SAMPLE, '1, '1, 16'h0000);
        send_beat(FUNC_READ,   '0, '0, 16'h0000);
        send_beat(FUNC_SAMPLE, '0, '0, 16'h0000);
        send_beat(FUNC_UNUSED, '1, '1, 16'hFFFF);
        send_beat(FUNC_CLEAR,  '1, '1, 16'h00FF);
        send_beat(FUNC_CLEAR,  '0, '0, 16'hFFFF);
        send_beat(FUNC_SAMPLE, '1, '1, 16'h0000);
        send_beat(FUNC_SAMPLE, '1, '1, 16'h0000);
        send_beat(FUNC_CLEAR,  '0, '0, 16'hAAAA);
        send_beat(FUNC_SAMPLE, {4{16'h5555}}, {4{16'hAAAA}}, 16'h0000);
        send_beat(FUNC_SAMPLE, {4{16'hAAAA}}, {4{16'h5555}}, 16'h0000);
        send_beat(FUNC_READ,   '1, '0, 16'hFFFF);
        send_beat(FUNC_CLEAR,  '0, '0, 16'h5555);
        send_beat(FUNC_SAMPLE, {16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF},
                  {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}, 16'h0000);
        send_beat(FUNC_CLEAR,  '0, '0, 16'hFFFF);
        send_beat(FUNC_SAMPLE, '0, '0, 16'h0000);
        wait_drained();

        for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
            if (chunk < 2) begin
                tx_idle_pct = 36;
                rx_idle_pct = 80;
            end else if (chunk < 4) begin
                tx_idle_pct = 80;
                rx_idle_pct = 36;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // pending bits are kept across each change of mask and enables
            case (chunk)
                0: apply_settings(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom));
                1: apply_settings(16'hFFFF, 16'hFFFF, 16'h0000,
                                  16'h0000, 16'h0000, 16'h0000, 16'h0000);
                2: apply_settings(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom) & 16'h7777, 16'($urandom) & 16'h7777,
                                  16'($urandom) & 16'h7777, 16'($urandom) & 16'h7777);
                3: apply_settings(16'h0000, 16'hFFFF, 16'hFFFF,
                                  16'h7777, 16'h7777, 16'h7777, 16'h7777);
                4: apply_settings(16'hFFFF, 16'h0000, 16'hFFFF,
                                  16'h3210, 16'h7654, 16'h3210, 16'h7654);
                5: apply_settings(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom));
                default: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF,
                                        16'h7531, 16'h6420, 16'hF8E9, 16'h1357);
            endcase
            if (chunk == 4)
                hold_requests++;
            for (int n = 0; n < CHUNK_BEATS; n++) begin
                if (chunk == 5 && n == CHUNK_BEATS / 2)
                    wait_drained();
                send_random_beat();
            end
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        sb.check_leftover();
        $display("Covered %0d beats of every function code under %0d register settings,",
                 sb.accepted, settings_used);
        $display("with idling on both sides, a long result stall and %0d results checked.",
                 sb.checked);
        if (sb.mismatches != 0) begin
            $display("RESULT: ERROR");
        end else begin
            $display("RESULT: OK");
        end
        $finish;
    end

endmodule
